// ----- sv/hbi_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the hermite tension/bias interpolator
// no dependencies

package hbi_pkg;

    localparam int CFG_BITS          = 16;
    localparam int CFG_INDEX_BITS    = 1;
    localparam int Q14_ONE           = 16384;
    localparam int WEIGHT_BITS       = 18;
    localparam int WEIGHT_FRAC       = 16;
    localparam int TAN_FRAC_BASE     = 59;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int POSITION_BITS_DEF = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_TENSION = 1'b0,
        CFG_BIAS    = 1'b1
    } t_cfg_idx;

    // tangent weights, unsigned q16
    typedef struct packed {
        logic [WEIGHT_BITS-1:0] ka;
        logic [WEIGHT_BITS-1:0] kb;
    } t_weights;

    // fraction bits kept in the tangents
    function automatic int tan_frac(input int sample_bits, input int position_bits);
        int raw;
        raw = TAN_FRAC_BASE - sample_bits - position_bits;
        return (raw < WEIGHT_FRAC) ? raw : WEIGHT_FRAC;
    endfunction

endpackage

// ----- sv/hbi_weights.sv -----
`timescale 1ns / 1ps
// tension/bias configuration registers and registered tangent weights
// depends on hbi_pkg

module hbi_weights (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [hbi_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [hbi_pkg::CFG_BITS-1:0]       i_cfg_data,
    output logic                               o_cfg_ready,
    output hbi_pkg::t_weights                  o_weights
);
    import hbi_pkg::*;

    localparam logic signed [CFG_BITS-1:0] Q14_POS = CFG_BITS'(Q14_ONE);
    localparam logic signed [CFG_BITS-1:0] Q14_NEG = -Q14_POS;
    localparam logic signed [CFG_BITS:0]   ONE_W   = (CFG_BITS+1)'(Q14_ONE);
    localparam logic [2*CFG_BITS-1:0]      K_RND   = (2*CFG_BITS)'(4096);
    localparam int                         K_SHIFT = 13;

    logic signed [CFG_BITS-1:0] r_tension, r_bias;
    logic signed [CFG_BITS-1:0] c_tension, c_bias;
    logic signed [CFG_BITS:0]   one_t_w, one_pb_w, one_mb_w;
    logic [2*CFG_BITS-1:0]      prod_a, prod_b;
    t_weights                   r_weights, n_weights;

    function automatic logic signed [CFG_BITS-1:0] clamp_q14(
        input logic signed [CFG_BITS-1:0] v
    );
        logic signed [CFG_BITS-1:0] res;
        res = v;
        if (v > Q14_POS) res = Q14_POS;
        if (v < Q14_NEG) res = Q14_NEG;
        return res;
    endfunction

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tension <= '0;
            r_bias    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TENSION: r_tension <= i_cfg_data;
                CFG_BIAS:    r_bias    <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        c_tension = clamp_q14(r_tension);
        c_bias    = clamp_q14(r_bias);
        one_t_w   = ONE_W - {c_tension[CFG_BITS-1], c_tension};
        one_pb_w  = ONE_W + {c_bias[CFG_BITS-1], c_bias};
        one_mb_w  = ONE_W - {c_bias[CFG_BITS-1], c_bias};
        prod_a    = one_pb_w[CFG_BITS-1:0] * one_t_w[CFG_BITS-1:0];
        prod_b    = one_mb_w[CFG_BITS-1:0] * one_t_w[CFG_BITS-1:0];
        n_weights.ka = WEIGHT_BITS'((prod_a + K_RND) >> K_SHIFT);
        n_weights.kb = WEIGHT_BITS'((prod_b + K_RND) >> K_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        r_weights <= n_weights;
    end

    assign o_weights = r_weights;

endmodule

// ----- sv/hbi_front.sv -----
`timescale 1ns / 1ps
// front pipeline: tangents from the sample differences and the hermite basis
// coefficients from the position; three register stages, depends on hbi_pkg

module hbi_front #(
    parameter  int SAMPLE_BITS   = hbi_pkg::SAMPLE_BITS_DEF,
    parameter  int POSITION_BITS = hbi_pkg::POSITION_BITS_DEF,
    localparam int TAN_FRAC      = hbi_pkg::tan_frac(SAMPLE_BITS, POSITION_BITS),
    localparam int M_BITS        = SAMPLE_BITS + TAN_FRAC + 4,
    localparam int A_BITS        = POSITION_BITS + 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [SAMPLE_BITS-1:0]   i_y0,
    input  logic signed [SAMPLE_BITS-1:0]   i_y1,
    input  logic signed [SAMPLE_BITS-1:0]   i_y2,
    input  logic signed [SAMPLE_BITS-1:0]   i_y3,
    input  logic [POSITION_BITS-1:0]        i_mu,
    input  hbi_pkg::t_weights               i_weights,
    output logic                            o_valid,
    output logic signed [SAMPLE_BITS-1:0]   o_y1,
    output logic signed [SAMPLE_BITS-1:0]   o_y2,
    output logic signed [M_BITS-1:0]        o_m0,
    output logic signed [M_BITS-1:0]        o_m1,
    output logic signed [A_BITS-1:0]        o_a0,
    output logic signed [A_BITS-1:0]        o_a1,
    output logic signed [A_BITS-1:0]        o_a2,
    output logic signed [A_BITS-1:0]        o_a3
);
    import hbi_pkg::*;

    localparam int S         = SAMPLE_BITS;
    localparam int P         = POSITION_BITS;
    localparam int PROD_BITS = S + WEIGHT_BITS + 2;
    localparam int RAW_BITS  = PROD_BITS + 1;
    localparam int TAN_SHIFT = WEIGHT_FRAC - TAN_FRAC;
    localparam logic signed [RAW_BITS-1:0] TAN_HALF = (RAW_BITS'(1) << TAN_SHIFT) >> 1;
    localparam logic [2*P:0]               POS_HALF = (2*P+1)'(1) << (P - 1);
    localparam logic signed [A_BITS-1:0]   A_ONE    = A_BITS'(1) << P;

    // stage 1: differences times weights, mu squared
    logic signed [S:0]             d0, d1, d2;
    logic signed [WEIGHT_BITS:0]   ka_s, kb_s;
    logic                          r_v1;
    logic signed [PROD_BITS-1:0]   r_p0a, r_p1b, r_p1a, r_p2b;
    logic [2*P-1:0]                r_sq;
    logic [P-1:0]                  r_mu1;
    logic signed [S-1:0]           r_y1_1, r_y2_1;

    assign d0   = {i_y1[S-1], i_y1} - {i_y0[S-1], i_y0};
    assign d1   = {i_y2[S-1], i_y2} - {i_y1[S-1], i_y1};
    assign d2   = {i_y3[S-1], i_y3} - {i_y2[S-1], i_y2};
    assign ka_s = {1'b0, i_weights.ka};
    assign kb_s = {1'b0, i_weights.kb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0a  <= d0 * ka_s;
        r_p1b  <= d1 * kb_s;
        r_p1a  <= d1 * ka_s;
        r_p2b  <= d2 * kb_s;
        r_sq   <= i_mu * i_mu;
        r_mu1  <= i_mu;
        r_y1_1 <= i_y1;
        r_y2_1 <= i_y2;
    end

    // stage 2: round tangents, round mu^2, mu^2 * mu
    logic signed [RAW_BITS-1:0] raw0, raw1;
    logic [2*P:0]               sq_rnd;
    logic [P-1:0]               mu2;
    logic                       r_v2;
    logic signed [M_BITS-1:0]   r_m0_2, r_m1_2;
    logic [2*P-1:0]             r_cube;
    logic [P-1:0]               r_mu2_2, r_mu_2;
    logic signed [S-1:0]        r_y1_2, r_y2_2;

    assign raw0   = RAW_BITS'(r_p0a) + RAW_BITS'(r_p1b) + TAN_HALF;
    assign raw1   = RAW_BITS'(r_p1a) + RAW_BITS'(r_p2b) + TAN_HALF;
    assign sq_rnd = {1'b0, r_sq} + POS_HALF;
    assign mu2    = sq_rnd[P +: P];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m0_2  <= M_BITS'(raw0 >>> TAN_SHIFT);
        r_m1_2  <= M_BITS'(raw1 >>> TAN_SHIFT);
        r_cube  <= mu2 * r_mu1;
        r_mu2_2 <= mu2;
        r_mu_2  <= r_mu1;
        r_y1_2  <= r_y1_1;
        r_y2_2  <= r_y2_1;
    end

    // stage 3: round mu^3, basis coefficients
    logic [2*P:0]               cube_rnd;
    logic signed [A_BITS-1:0]   s1, s2, s3;
    logic                       r_v3;
    logic signed [A_BITS-1:0]   r_a0, r_a1, r_a2, r_a3;
    logic signed [M_BITS-1:0]   r_m0_3, r_m1_3;
    logic signed [S-1:0]        r_y1_3, r_y2_3;

    assign cube_rnd = {1'b0, r_cube} + POS_HALF;
    assign s1       = {3'b000, r_mu_2};
    assign s2       = {3'b000, r_mu2_2};
    assign s3       = {3'b000, cube_rnd[P +: P]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a0   <= (s3 <<< 1) - s2 - (s2 <<< 1) + A_ONE;
        r_a1   <= s3 - (s2 <<< 1) + s1;
        r_a2   <= s3 - s2;
        r_a3   <= s2 + (s2 <<< 1) - (s3 <<< 1);
        r_m0_3 <= r_m0_2;
        r_m1_3 <= r_m1_2;
        r_y1_3 <= r_y1_2;
        r_y2_3 <= r_y2_2;
    end

    assign o_valid = r_v3;
    assign o_y1    = r_y1_3;
    assign o_y2    = r_y2_3;
    assign o_m0    = r_m0_3;
    assign o_m1    = r_m1_3;
    assign o_a0    = r_a0;
    assign o_a1    = r_a1;
    assign o_a2    = r_a2;
    assign o_a3    = r_a3;

endmodule

// ----- sv/hbi_combine.sv -----
`timescale 1ns / 1ps
// back pipeline: basis times samples and tangents, sum, round and saturate;
// three register stages, depends on hbi_pkg

module hbi_combine #(
    parameter  int SAMPLE_BITS   = hbi_pkg::SAMPLE_BITS_DEF,
    parameter  int POSITION_BITS = hbi_pkg::POSITION_BITS_DEF,
    localparam int TAN_FRAC      = hbi_pkg::tan_frac(SAMPLE_BITS, POSITION_BITS),
    localparam int M_BITS        = SAMPLE_BITS + TAN_FRAC + 4,
    localparam int A_BITS        = POSITION_BITS + 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [SAMPLE_BITS-1:0]   i_y1,
    input  logic signed [SAMPLE_BITS-1:0]   i_y2,
    input  logic signed [M_BITS-1:0]        i_m0,
    input  logic signed [M_BITS-1:0]        i_m1,
    input  logic signed [A_BITS-1:0]        i_a0,
    input  logic signed [A_BITS-1:0]        i_a1,
    input  logic signed [A_BITS-1:0]        i_a2,
    input  logic signed [A_BITS-1:0]        i_a3,
    output logic                            o_valid,
    output logic signed [SAMPLE_BITS-1:0]   o_interpolated,
    output logic                            o_clipped
);
    import hbi_pkg::*;

    localparam int S         = SAMPLE_BITS;
    localparam int P         = POSITION_BITS;
    localparam int M_LO      = M_BITS / 2;
    localparam int M_HI      = M_BITS - M_LO;
    localparam int YP_BITS   = A_BITS + S;
    localparam int LP_BITS   = A_BITS + M_LO + 1;
    localparam int HP_BITS   = A_BITS + M_HI;
    localparam int ACC_BITS  = P + S + TAN_FRAC + 8;
    localparam int RND_SHIFT = P + TAN_FRAC;
    localparam int RES_BITS  = ACC_BITS - RND_SHIFT;
    localparam logic signed [ACC_BITS-1:0] RND_HALF = ACC_BITS'(1) << (RND_SHIFT - 1);
    localparam logic signed [RES_BITS-1:0] SAT_HI   = RES_BITS'({1'b0, {(S-1){1'b1}}});
    localparam logic signed [RES_BITS-1:0] SAT_LO   = ~SAT_HI;

    // stage 4: products, tangent words split in halves
    logic                        r_v4;
    logic signed [YP_BITS-1:0]   r_py1, r_py2;
    logic signed [LP_BITS-1:0]   r_pm0l, r_pm1l;
    logic signed [HP_BITS-1:0]   r_pm0h, r_pm1h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_py1  <= i_a0 * i_y1;
        r_py2  <= i_a3 * i_y2;
        r_pm0l <= i_a1 * $signed({1'b0, i_m0[M_LO-1:0]});
        r_pm0h <= i_a1 * $signed(i_m0[M_BITS-1:M_LO]);
        r_pm1l <= i_a2 * $signed({1'b0, i_m1[M_LO-1:0]});
        r_pm1h <= i_a2 * $signed(i_m1[M_BITS-1:M_LO]);
    end

    // stage 5: accumulate
    logic                        r_v5;
    logic signed [ACC_BITS-1:0]  r_acc, n_acc;

    always_comb begin
        n_acc = ((ACC_BITS'(r_py1) + ACC_BITS'(r_py2)) <<< TAN_FRAC)
              + (ACC_BITS'(r_pm0h) <<< M_LO) + ACC_BITS'(r_pm0l)
              + (ACC_BITS'(r_pm1h) <<< M_LO) + ACC_BITS'(r_pm1l);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // stage 6: round half up, saturate
    logic signed [ACC_BITS-1:0]  acc_rnd;
    logic signed [RES_BITS-1:0]  res;
    logic signed [S-1:0]         n_interp;
    logic                        n_clip;
    logic                        r_v6;
    logic signed [S-1:0]         r_interp;
    logic                        r_clip;

    assign acc_rnd = r_acc + RND_HALF;
    assign res     = RES_BITS'(acc_rnd >>> RND_SHIFT);

    always_comb begin
        priority if (res > SAT_HI) begin
            n_interp = SAT_HI[S-1:0];
            n_clip   = 1'b1;
        end else if (res < SAT_LO) begin
            n_interp = SAT_LO[S-1:0];
            n_clip   = 1'b1;
        end else begin
            n_interp = res[S-1:0];
            n_clip   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_interp <= n_interp;
        r_clip   <= n_clip;
    end

    assign o_valid        = r_v6;
    assign o_interpolated = r_interp;
    assign o_clipped      = r_clip;

endmodule

// ----- sv/hermite_tension_bias_interpolator.sv -----
`timescale 1ns / 1ps
// Four-point cubic hermite interpolator with tension and bias. A new request
// is taken on every clock (start high, busy low; busy is high only in reset).
// Results come back in request order. o_valid marks o_interpolated/o_clipped
// for one cycle. The seven register stages are: input, differences times
// weights, tangent rounding with mu^3, basis, basis products, sum,
// round/saturate. There is no backpressure: the receiver must take each
// result in its strobe cycle.
// Tension/bias writes reach the datapath through the registered tangent weights.
// depends on hbi_pkg, hbi_weights, hbi_front, hbi_combine

module hermite_tension_bias_interpolator #(
    parameter int SAMPLE_BITS   = hbi_pkg::SAMPLE_BITS_DEF,
    parameter int POSITION_BITS = hbi_pkg::POSITION_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample_before,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample_start,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample_end,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample_after,
    input  logic [POSITION_BITS-1:0]           i_position,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hbi_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [hbi_pkg::CFG_BITS-1:0]       i_cfg_data,
    output logic                               o_valid,
    output logic signed [SAMPLE_BITS-1:0]      o_interpolated,
    output logic                               o_clipped
);
    import hbi_pkg::*;

    localparam int TAN_FRAC   = tan_frac(SAMPLE_BITS, POSITION_BITS);
    localparam int M_BITS     = SAMPLE_BITS + TAN_FRAC + 4;
    localparam int A_BITS     = POSITION_BITS + 3;
    localparam int PIPE_DEPTH = 7;
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                          accept;
    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_y0, r_y1, r_y2, r_y3;
    logic [POSITION_BITS-1:0]      r_mu;
    t_weights                      weights;

    logic                          fr_valid;
    logic signed [SAMPLE_BITS-1:0] fr_y1, fr_y2;
    logic signed [M_BITS-1:0]      fr_m0, fr_m1;
    logic signed [A_BITS-1:0]      fr_a0, fr_a1, fr_a2, fr_a3;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y0 <= i_sample_before;
        r_y1 <= i_sample_start;
        r_y2 <= i_sample_end;
        r_y3 <= i_sample_after;
        r_mu <= i_position;
    end

    hbi_weights u_weights (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_weights   (weights)
    );

    hbi_front #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_in_valid),
        .i_y0      (r_y0),
        .i_y1      (r_y1),
        .i_y2      (r_y2),
        .i_y3      (r_y3),
        .i_mu      (r_mu),
        .i_weights (weights),
        .o_valid   (fr_valid),
        .o_y1      (fr_y1),
        .o_y2      (fr_y2),
        .o_m0      (fr_m0),
        .o_m1      (fr_m1),
        .o_a0      (fr_a0),
        .o_a1      (fr_a1),
        .o_a2      (fr_a2),
        .o_a3      (fr_a3)
    );

    hbi_combine #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_combine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (fr_valid),
        .i_y1           (fr_y1),
        .i_y2           (fr_y2),
        .i_m0           (fr_m0),
        .i_m1           (fr_m1),
        .i_a0           (fr_a0),
        .i_a1           (fr_a1),
        .i_a2           (fr_a2),
        .i_a3           (fr_a3),
        .o_valid        (o_valid),
        .o_interpolated (o_interpolated),
        .o_clipped      (o_clipped)
    );

    // every accepted transaction produces exactly one strobe
    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##PIPE_DEPTH o_valid)
        else $error("accepted transaction produced no result");

    a_result_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, PIPE_DEPTH))
        else $error("result without an accepted transaction");

    // a clipped result sits at a rail
    a_clip_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |-> (o_interpolated == OUT_MAX || o_interpolated == OUT_MIN))
        else $error("clipped result not at a rail");

    // both handshakes closed during reset
    a_no_cfg_in_reset: assert property (@(posedge i_clk)
        !i_rst_n |-> !o_cfg_ready && busy)
        else $error("ports open during reset");

endmodule
